// ----- rtl/lcrf_pkg.sv -----
// Shared constants, codes and types of the line-collecting ring flusher.
package lcrf_pkg;

	localparam int DEPTH   = 32;
	localparam int PTR_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int DATA_W  = 8;
	localparam int LEVEL_W = 6;
	localparam int CMP_W   = (CNT_W > LEVEL_W) ? CNT_W : LEVEL_W;

	localparam logic [1:0] ACT_RX   = 2'd0;
	localparam logic [1:0] ACT_ACK  = 2'd1;
	localparam logic [1:0] ACT_FAIL = 2'd2;

	localparam logic CFG_LINE_END    = 1'b0;
	localparam logic CFG_FLUSH_LEVEL = 1'b1;

	localparam logic [DATA_W-1:0]  LINE_END_RST = 8'd10;
	localparam logic [LEVEL_W-1:0] LEVEL_RST    = 6'd30;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic take;
		logic rd_en;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic start;
		logic last;
		logic out_free;
	} sts_t;

	// Sums of a position and a count stay below twice the depth.
	function automatic logic [PTR_W-1:0] wrap_idx(input logic [CNT_W:0] s);
		logic [CNT_W:0] r;
		r = (s >= (CNT_W + 1)'(DEPTH)) ? s - (CNT_W + 1)'(DEPTH) : s;
		return r[PTR_W-1:0];
	endfunction

endpackage

// ----- rtl/lcrf_ctrl.sv -----
// Controller: accepts items when idle and sequences the read-out of a run.
module lcrf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  lcrf_pkg::sts_t sts,
	output lcrf_pkg::cmd_t cmd
);
	import lcrf_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && sts.start) begin
					state_nxt = ST_READ;
				end
			end
			ST_READ: begin
				state_nxt = ST_LOAD;
			end
			ST_LOAD: begin
				if (sts.out_free) begin
					state_nxt = sts.last ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		cmd.take  = 1'b0;
		cmd.rd_en = 1'b0;
		cmd.load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.take = s_tvalid;
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
			end
			ST_LOAD: begin
				cmd.load = sts.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

// ----- rtl/lcrf_datapath.sv -----
// Datapath: byte store, pointers, configuration and the output register.
module lcrf_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [lcrf_pkg::DATA_W-1:0]   cfg_data,
	input  logic [1:0]                    action,
	input  logic [lcrf_pkg::DATA_W-1:0]   rx_byte,
	input  lcrf_pkg::cmd_t                cmd,
	output lcrf_pkg::sts_t                sts,
	input  logic                          m_tready,
	output logic                          m_tvalid,
	output logic [lcrf_pkg::DATA_W-1:0]   tx_byte,
	output logic                          chunk_last
);
	import lcrf_pkg::*;

	logic [DATA_W-1:0]  mem [DEPTH];
	logic [DATA_W-1:0]  rdata_q;
	logic [DATA_W-1:0]  line_end_q;
	logic [LEVEL_W-1:0] level_q;
	logic [PTR_W-1:0]   rp_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   pend_q;
	logic [CNT_W-1:0]   k_q;
	logic               flushing_q;
	logic               m_tvalid_q;
	logic [DATA_W-1:0]  tx_q;
	logic               last_q;

	logic [PTR_W-1:0]   wr_addr;
	logic [PTR_W-1:0]   rd_addr;
	logic               not_full;
	logic [CNT_W-1:0]   cnt_inc;
	logic [CNT_W-1:0]   retire;
	logic [PTR_W-1:0]   nxt_rp;
	logic [CNT_W-1:0]   nxt_cnt;
	logic               nxt_flushing;
	logic               start;
	logic               wr_en;
	logic [CNT_W:0]     run_end;
	logic [CNT_W-1:0]   run_len;

	always_comb begin
		wr_addr  = wrap_idx((CNT_W + 1)'(rp_q) + (CNT_W + 1)'(cnt_q));
		rd_addr  = wrap_idx((CNT_W + 1)'(rp_q) + (CNT_W + 1)'(k_q));
		not_full = cnt_q < CNT_W'(DEPTH);
		cnt_inc  = cnt_q + CNT_W'(1);
		retire   = (pend_q <= cnt_q) ? pend_q : cnt_q;

		nxt_rp       = rp_q;
		nxt_cnt      = cnt_q;
		nxt_flushing = flushing_q;
		start        = 1'b0;
		wr_en        = 1'b0;
		case (action)
			ACT_RX: begin
				if (not_full) begin
					wr_en   = 1'b1;
					nxt_cnt = cnt_inc;
					start   = !flushing_q && (rx_byte == line_end_q ||
						CMP_W'(cnt_inc) > CMP_W'(level_q));
				end
			end
			ACT_ACK: begin
				if (flushing_q) begin
					if (pend_q != '0) begin
						nxt_cnt = cnt_q - retire;
						nxt_rp  = wrap_idx((CNT_W + 1)'(rp_q) + (CNT_W + 1)'(pend_q));
					end
					start = (nxt_cnt != '0);
					if (!start) begin
						nxt_flushing = 1'b0;
					end
				end
			end
			ACT_FAIL: begin
				nxt_flushing = 1'b0;
			end
			default: begin
				nxt_flushing = flushing_q;
			end
		endcase
		if (start) begin
			nxt_flushing = 1'b1;
		end

		// A run stops at the count or at the end of the ring, whichever is first.
		run_end = (CNT_W + 1)'(nxt_rp) + (CNT_W + 1)'(nxt_cnt);
		run_len = (run_end < (CNT_W + 1)'(DEPTH)) ? nxt_cnt
			: CNT_W'(DEPTH) - CNT_W'(nxt_rp);

		sts.start    = start;
		sts.last     = (k_q + CNT_W'(1)) == pend_q;
		sts.out_free = !m_tvalid_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_end_q <= LINE_END_RST;
			level_q    <= LEVEL_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_LINE_END) begin
				line_end_q <= cfg_data;
			end else begin
				level_q <= cfg_data[LEVEL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q       <= '0;
			cnt_q      <= '0;
			pend_q     <= '0;
			k_q        <= '0;
			flushing_q <= 1'b0;
		end else if (cmd.take) begin
			rp_q       <= nxt_rp;
			cnt_q      <= nxt_cnt;
			flushing_q <= nxt_flushing;
			if (start) begin
				pend_q <= run_len;
				k_q    <= '0;
			end else if (action == ACT_ACK && flushing_q) begin
				pend_q <= '0;
			end
		end else if (cmd.load) begin
			k_q <= k_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && wr_en) begin
			mem[wr_addr] <= rx_byte;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tx_q   <= rdata_q;
			last_q <= sts.last;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign tx_byte    = tx_q;
	assign chunk_last = last_q;

endmodule

// ----- rtl/line_collecting_ring_flusher_top.sv -----
// Top level of the line-collecting ring flusher.
//
//  channel | direction | handshake           | payload
//  s       | in        | s_tvalid / s_tready | s_tuser: action; s_tdata: rx_byte
//  m       | out       | m_tvalid / m_tready | m_tdata: tx_byte; m_tlast: chunk_last
//  cfg     | in        | cfg_we              | cfg_index, cfg_data
//
// An item that starts no run leaves the block idle, so s_tready stays high for the next item.
// An item that starts a run emits its bytes one by one, each by a registered store read and
// then an output load once the output register is free; no item is taken meanwhile.
// The output register lets the last byte wait for m_tready while the next item is taken.
// Reset clears pointers, counts and the flush flag; the store contents need no clearing.
module line_collecting_ring_flusher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [1:0]  s_tuser,   // [1:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] tx_byte
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);
	import lcrf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	lcrf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lcrf_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.action     (s_tuser),
		.rx_byte    (s_tdata),
		.cmd        (cmd),
		.sts        (sts),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.tx_byte    (m_tdata),
		.chunk_last (m_tlast)
	);

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench of the line-collecting ring flusher: directed and random items.
`timescale 1ns / 100ps

module testbench;
	import lcrf_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE      = 6;

	// The one action code that the block ignores.
	localparam logic [1:0] ACT_NOP = 2'd3;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              last;
	} tx_beat_t;

	// Tracks the ring store and predicts every flushed byte.
	class ring_flush_tracker;
		logic [DATA_W-1:0]  store [DEPTH];
		logic [PTR_W-1:0]   rd_pos;
		logic [CNT_W-1:0]   count;
		logic [CNT_W-1:0]   in_flight;
		bit                 flushing;
		logic [DATA_W-1:0]  line_end;
		logic [LEVEL_W-1:0] level;
		tx_beat_t           flushed_bytes [$];
		int                 n_changed, n_checked, n_runs, n_dropped, n_errors;

		function new();
			rd_pos    = '0;
			count     = '0;
			in_flight = '0;
			flushing  = 1'b0;
			line_end  = LINE_END_RST;
			level     = LEVEL_RST;
			n_changed = 0;
			n_checked = 0;
			n_runs    = 0;
			n_dropped = 0;
			n_errors  = 0;
		endfunction

		// A run ends at the stored count or at the wrap end of the store.
		function void emit_run();
			tx_beat_t beat;
			flushing = 1'b1;
			if (int'(rd_pos) + int'(count) < DEPTH)
				in_flight = count;
			else
				in_flight = CNT_W'(DEPTH - int'(rd_pos));
			for (int k = 0; k < int'(in_flight); k++) begin
				beat.data = store[(int'(rd_pos) + k) % DEPTH];
				beat.last = (k + 1 == int'(in_flight));
				flushed_bytes.push_back(beat);
			end
			if (in_flight != 0)
				n_runs++;
		endfunction

		function void take_item(input logic [1:0] act, input logic [DATA_W-1:0] rx);
			case (act)
			ACT_RX: begin
				if (count < DEPTH) begin
					store[(int'(rd_pos) + int'(count)) % DEPTH] = rx;
					count = count + 1'b1;
					n_changed++;
					if (!flushing && (rx == line_end || count > level))
						emit_run();
				end else begin
					n_dropped++;
				end
			end
			ACT_ACK: begin
				if (flushing) begin
					n_changed++;
					if (in_flight != 0) begin
						count = count - ((in_flight <= count) ? in_flight : count);
						rd_pos = PTR_W'((int'(rd_pos) + int'(in_flight)) % DEPTH);
						in_flight = '0;
					end
					if (count != 0)
						emit_run();
					else
						flushing = 1'b0;
				end
			end
			ACT_FAIL: begin
				if (flushing)
					n_changed++;
				flushing = 1'b0;
			end
			default: begin
			end
			endcase
		endfunction

		function void take_byte(input logic [DATA_W-1:0] data, input logic last);
			tx_beat_t want;
			if (flushed_bytes.size() == 0) begin
				$display("%0t: unexpected tx_byte %h chunk_last %b", $time, data, last);
				n_errors++;
				return;
			end
			want = flushed_bytes.pop_front();
			n_checked++;
			if (data !== want.data) begin
				$display("%0t: tx_byte expected %h, got %h", $time, want.data, data);
				n_errors++;
			end
			if (last !== want.last) begin
				$display("%0t: chunk_last expected %b, got %b", $time, want.last, last);
				n_errors++;
			end
		endfunction

		function void set_reg(input logic idx, input logic [7:0] val);
			if (idx == CFG_LINE_END)
				line_end = val;
			else
				level = val[LEVEL_W-1:0];
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        cfg_we;
	logic        cfg_index;
	logic [7:0]  cfg_data;

	ring_flush_tracker tracker = new();
	int          cycles = 0;
	int          burst_left = 0;
	bit          steady = 1'b0;
	bit          choke_req = 1'b0;
	logic [7:0]  cur_line_end = LINE_END_RST;
	int          settings = 1;

	line_collecting_ring_flusher_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				tracker.take_byte(m_tdata, m_tlast);
			if (s_tvalid && s_tready)
				tracker.take_item(s_tuser, s_tdata);
			if (cfg_we)
				tracker.set_reg(cfg_index, cfg_data);
		end
	end

	// The receiver switches among stall patterns and holds off once for a long stretch.
	initial begin : receiver
		int         phase_left;
		int         mode;
		logic [7:0] pattern;
		phase_left = 0;
		mode = 0;
		pattern = 8'b1011_0110;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (choke_req && m_tvalid) begin
				choke_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (phase_left == 0) begin
				mode = $urandom_range(0, 3);
				phase_left = $urandom_range(16, 120);
			end
			phase_left--;
			pattern = {pattern[6:0], pattern[7]};
			case (mode)
			0: m_tready <= 1'b1;
			1: m_tready <= pattern[0];
			2: m_tready <= ($urandom_range(0, 3) != 0);
			default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	task automatic send_item(input logic [1:0] action, input logic [7:0] rx);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (!steady) begin
				gap = $urandom_range(1, 6);
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		// A full store while idle can never drain again, so keep the stimulus out of it.
		if (action == ACT_FAIL && int'(tracker.count) == DEPTH)
			action = ACT_ACK;
		if (action == ACT_RX && !tracker.flushing && int'(tracker.count) == DEPTH - 1 &&
				int'(tracker.level) >= DEPTH)
			rx = tracker.line_end;
		s_tvalid <= 1'b1;
		s_tuser  <= action;
		s_tdata  <= rx;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tracker.flushed_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic [7:0] le, input logic [LEVEL_W-1:0] lvl);
		write_reg(CFG_LINE_END, le);
		write_reg(CFG_FLUSH_LEVEL, {2'b00, lvl});
		cur_line_end = le;
		settings++;
	endtask

	task automatic send_line(input int len);
		logic [7:0] b;
		for (int k = 0; k < len; k++) begin
			b = 8'($urandom_range(0, 255));
			if (b == cur_line_end)
				b = ~b;
			send_item(ACT_RX, b);
		end
		send_item(ACT_RX, cur_line_end);
	endtask

	// Acknowledges retire runs; an occasional failure leaves the bytes in place.
	task automatic send_acks();
		int n;
		n = $urandom_range(1, 4);
		repeat (n) begin
			if ($urandom_range(0, 9) == 0)
				send_item(ACT_FAIL, 8'($urandom_range(0, 255)));
			else
				send_item(ACT_ACK, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic random_phase(input int goal);
		int start;
		int pick;
		start = tracker.n_changed;
		steady = $urandom_range(0, 2) == 0;
		while (tracker.n_changed - start < goal) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				if ($urandom_range(0, 7) == 0)
					send_line($urandom_range(13, 40));
				else
					send_line($urandom_range(0, 12));
				send_acks();
			end else if (pick < 7) begin
				// Enough bytes to fill the store and have some dropped.
				repeat (36) send_item(ACT_RX, 8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 6))
					send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end
		end
		drain();
	endtask

	initial begin : stimulus
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		cfg_we    = 1'b0;
		cfg_index = 1'b0;
		cfg_data  = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Idle failure, idle acknowledge, the unused action, then two line-end runs.
		send_item(ACT_FAIL, 8'h00);
		send_item(ACT_ACK, 8'hFF);
		send_item(ACT_NOP, 8'hFF);
		send_item(ACT_RX, 8'h00);
		send_item(ACT_RX, 8'hFF);
		send_item(ACT_RX, LINE_END_RST);
		send_item(ACT_RX, 8'h41);
		send_item(ACT_FAIL, 8'h00);
		send_item(ACT_RX, LINE_END_RST);
		send_item(ACT_ACK, 8'h00);
		send_item(ACT_ACK, 8'h00);
		drain();

		// With a zero level every stored byte starts a run; bytes during a run start none.
		set_config(8'hFF, 6'd0);
		send_item(ACT_RX, 8'h55);
		send_item(ACT_RX, 8'hAA);
		send_item(ACT_ACK, 8'h00);
		send_item(ACT_ACK, 8'h00);
		send_item(ACT_RX, 8'hFF);
		send_item(ACT_ACK, 8'h00);
		drain();

		set_config(8'h00, 6'd0);
		random_phase(50);
		set_config(8'hFF, 6'd32);
		choke_req = 1'b1;
		random_phase(60);
		repeat (3) begin
			set_config(8'($urandom_range(0, 255)), 6'($urandom_range(0, 32)));
			random_phase(60);
		end

		$display("Checked %0d bytes in %0d runs from %0d state-changing items (%0d dropped)",
			tracker.n_checked, tracker.n_runs, tracker.n_changed, tracker.n_dropped);
		$display("under %0d register settings, with a long output stall and full-store drops.",
			settings);
		if (tracker.n_errors == 0 && tracker.flushed_bytes.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- line_collecting_ring_flusher_top.f -----
rtl/lcrf_pkg.sv
rtl/lcrf_ctrl.sv
rtl/lcrf_datapath.sv
rtl/line_collecting_ring_flusher_top.sv
tb/testbench.sv
